[sv/disk_request_scheduler_macros.svh]
// assertion macros for the disk request scheduler
`ifndef DISK_REQUEST_SCHEDULER_MACROS_SVH
`define DISK_REQUEST_SCHEDULER_MACROS_SVH

// same-cycle implication, checked on clk outside reset
`define DRS_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk outside reset
`define DRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/drs_pkg.sv]
// shared types and constants of the disk request scheduler
package drs_pkg;

  localparam int QUEUE_DEPTH_DEF = 64;
  localparam int TRACK_BITS_DEF  = 16;
  localparam int FIELD_BITS      = 16;
  localparam int TAG_BITS        = 16;
  localparam int POLICY_BITS     = 3;

  typedef enum logic [POLICY_BITS-1:0] {
    POL_FIFO  = 3'd0,
    POL_SSTF  = 3'd1,
    POL_LOOK  = 3'd2,
    POL_CLOOK = 3'd3,
    POL_FLOOK = 3'd4
  } policy_t;

  typedef enum logic [1:0] {
    STAT_GRANTED = 2'd0,
    STAT_NONE    = 2'd1,
    STAT_ADDED   = 2'd2,
    STAT_DROPPED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SIDE_ANY  = 2'd0,
    SIDE_UP   = 2'd1,
    SIDE_DOWN = 2'd2
  } side_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_SCAN  = 2'd1,
    S_SHIFT = 2'd2,
    S_FIN   = 2'd3
  } state_t;

  // unused codes fall back to fifo
  function automatic policy_t decode_policy(logic [POLICY_BITS-1:0] code);
    policy_t pol;
    unique case (code)
      POL_SSTF:  pol = POL_SSTF;
      POL_LOOK:  pol = POL_LOOK;
      POL_CLOOK: pol = POL_CLOOK;
      POL_FLOOK: pol = POL_FLOOK;
      default:   pol = POL_FIFO;
    endcase
    return pol;
  endfunction

endpackage

[sv/drs_if.sv]
// handshake channels of the disk request scheduler

interface drs_req_if;
  import drs_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  mode;
  logic [FIELD_BITS-1:0] request_track;
  logic [TAG_BITS-1:0]   request_tag;
  logic [FIELD_BITS-1:0] head_track;
  modport source (output valid, mode, request_track, request_tag, head_track, input ready);
  modport sink (input valid, mode, request_track, request_tag, head_track, output ready);
endinterface

interface drs_rsp_if;
  import drs_pkg::*;
  logic                  valid;
  logic                  ready;
  status_t               status;
  logic [FIELD_BITS-1:0] granted_track;
  logic [TAG_BITS-1:0]   granted_tag;
  logic                  sweep_up;
  logic                  queue_empty;
  modport source (output valid, status, granted_track, granted_tag, sweep_up, queue_empty,
                  input ready);
  modport sink (input valid, status, granted_track, granted_tag, sweep_up, queue_empty,
                output ready);
endinterface

interface drs_cfg_if;
  import drs_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [POLICY_BITS-1:0] policy;
  modport source (output valid, policy, input ready);
  modport sink (input valid, policy, output ready);
endinterface

[sv/disk_request_scheduler.sv]
// disk request scheduler: pending request table with fifo, sstf, look, c-look, f-look pick
//
// Requests are kept compacted in arrival order in a single-port-write,
// single-port-read table of QUEUE_DEPTH entries. An add passes through S_FIN
// to the output register. A poll walks the table with one shared seek compare
// unit, one entry per cycle behind the registered table read, and look,
// f-look and c-look may need a second pass when nothing lies in the first
// search direction. The granted entry is then closed up by moving every
// younger entry down one slot, one per cycle. For fifo the scan covers only
// the oldest entry. No input is taken while a poll is at work. The f-look
// active batch is always the oldest run of entries, so it is held as a
// length, not a mark per entry. No clearing pass is needed after reset:
// the entry count alone tells which entries hold requests. A finished
// result sits in an output register, so the next request can be
// accepted while the result waits.
module disk_request_scheduler #(
  parameter int QUEUE_DEPTH = drs_pkg::QUEUE_DEPTH_DEF,
  parameter int TRACK_BITS  = drs_pkg::TRACK_BITS_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  drs_cfg_if.sink   cfg_wr,
  drs_req_if.sink   in_req,
  drs_rsp_if.source out_rsp
);
  import drs_pkg::*;
  `include "disk_request_scheduler_macros.svh"

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int MW = TRACK_BITS + TAG_BITS;

  // request table
  logic [MW-1:0] mem [QUEUE_DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [MW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [MW-1:0] mem_rdata_r;

  // control state
  state_t                 state_r, state_nxt;
  logic [POLICY_BITS-1:0] policy_r, policy_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic [CW-1:0]          active_r, active_nxt;   // length of f-look batch
  logic                   dir_r, dir_nxt;
  logic                   out_valid_r, out_valid_nxt;

  // per-poll working registers
  policy_t               pol_r, pol_nxt;
  side_t                 side_r, side_nxt;
  logic [TRACK_BITS-1:0] head_r, head_nxt;
  logic [TRACK_BITS-1:0] scan_head_r, scan_head_nxt;
  logic [CW-1:0]         lim_r, lim_nxt;
  logic [CW-1:0]         rd_idx_r, rd_idx_nxt;     // read pointer, scan and shift
  logic                  cmp_vld_r, cmp_vld_nxt;   // read data valid this cycle
  logic [AW-1:0]         cmp_idx_r, cmp_idx_nxt;   // entry behind the read data
  logic                  pass2_r, pass2_nxt;
  logic                  best_found_r, best_found_nxt;
  logic [AW-1:0]         best_idx_r, best_idx_nxt;
  logic [TRACK_BITS-1:0] best_dist_r, best_dist_nxt;
  logic [TRACK_BITS-1:0] best_track_r, best_track_nxt;
  logic [TAG_BITS-1:0]   best_tag_r, best_tag_nxt;

  // staged result and output register
  status_t               res_status_r, res_status_nxt;
  logic [TRACK_BITS-1:0] res_track_r, res_track_nxt;
  logic [TAG_BITS-1:0]   res_tag_r, res_tag_nxt;
  status_t               out_status_r, out_status_nxt;
  logic [FIELD_BITS-1:0] out_track_r, out_track_nxt;
  logic [TAG_BITS-1:0]   out_tag_r, out_tag_nxt;
  logic                  out_sweep_r, out_sweep_nxt;
  logic                  out_empty_r, out_empty_nxt;

  // seek unit hookup
  logic [TRACK_BITS-1:0] rd_track;
  logic [TAG_BITS-1:0]   rd_tag;
  logic                  seek_take;
  logic [TRACK_BITS-1:0] seek_dist;
  logic [CW-1:0]         batch_len;

  // poll accepted while the table is empty
  logic                  poll_on_empty;

  assign rd_track = mem_rdata_r[MW-1:TAG_BITS];
  assign rd_tag   = mem_rdata_r[TAG_BITS-1:0];

  drs_seek_unit #(
    .TRACK_BITS (TRACK_BITS)
  ) u_seek (
    .side       (side_r),
    .track      (rd_track),
    .head       (scan_head_r),
    .best_found (best_found_r),
    .best_dist  (best_dist_r),
    .take       (seek_take),
    .seek_len   (seek_dist)
  );

  // f-look swaps every pending request in when its batch has run dry
  assign batch_len = (active_r == '0) ? count_r : active_r;

  assign in_req.ready = (state_r == S_IDLE);
  assign cfg_wr.ready = (state_r == S_IDLE);

  assign poll_on_empty = (state_r == S_IDLE) && in_req.valid && in_req.mode && (count_r == '0);

  assign out_rsp.valid         = out_valid_r;
  assign out_rsp.status        = out_status_r;
  assign out_rsp.granted_track = out_track_r;
  assign out_rsp.granted_tag   = out_tag_r;
  assign out_rsp.sweep_up      = out_sweep_r;
  assign out_rsp.queue_empty   = out_empty_r;

  always_comb begin
    state_nxt      = state_r;
    policy_nxt     = policy_r;
    count_nxt      = count_r;
    active_nxt     = active_r;
    dir_nxt        = dir_r;
    out_valid_nxt  = out_valid_r;
    pol_nxt        = pol_r;
    side_nxt       = side_r;
    head_nxt       = head_r;
    scan_head_nxt  = scan_head_r;
    lim_nxt        = lim_r;
    rd_idx_nxt     = rd_idx_r;
    cmp_vld_nxt    = 1'b0;
    cmp_idx_nxt    = cmp_idx_r;
    pass2_nxt      = pass2_r;
    best_found_nxt = best_found_r;
    best_idx_nxt   = best_idx_r;
    best_dist_nxt  = best_dist_r;
    best_track_nxt = best_track_r;
    best_tag_nxt   = best_tag_r;
    res_status_nxt = res_status_r;
    res_track_nxt  = res_track_r;
    res_tag_nxt    = res_tag_r;
    out_status_nxt = out_status_r;
    out_track_nxt  = out_track_r;
    out_tag_nxt    = out_tag_r;
    out_sweep_nxt  = out_sweep_r;
    out_empty_nxt  = out_empty_r;
    mem_we         = 1'b0;
    mem_waddr      = count_r[AW-1:0];
    mem_wdata      = {TRACK_BITS'(in_req.request_track), in_req.request_tag};
    mem_raddr      = rd_idx_r[AW-1:0];

    if (cfg_wr.valid && cfg_wr.ready) begin
      policy_nxt = cfg_wr.policy;
    end

    if (out_valid_r && out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_req.valid) begin
          res_track_nxt = '0;
          res_tag_nxt   = '0;
          state_nxt     = S_FIN;
          if (!in_req.mode) begin
            // add request at the tail
            if (count_r == CW'(QUEUE_DEPTH)) begin
              res_status_nxt = STAT_DROPPED;
            end else begin
              mem_we         = 1'b1;
              count_nxt      = count_r + CW'(1);
              res_status_nxt = STAT_ADDED;
            end
          end else if (count_r == '0) begin
            res_status_nxt = STAT_NONE;
          end else begin
            // set up the first search pass
            pol_nxt        = decode_policy(policy_r);
            head_nxt       = TRACK_BITS'(in_req.head_track);
            scan_head_nxt  = TRACK_BITS'(in_req.head_track);
            rd_idx_nxt     = '0;
            best_found_nxt = 1'b0;
            pass2_nxt      = 1'b0;
            lim_nxt        = count_r;
            side_nxt       = dir_r ? SIDE_UP : SIDE_DOWN;
            state_nxt      = S_SCAN;
            unique case (decode_policy(policy_r))
              POL_FIFO: begin
                side_nxt = SIDE_ANY;
                lim_nxt  = CW'(1);
              end
              POL_SSTF:  side_nxt = SIDE_ANY;
              POL_CLOOK: side_nxt = SIDE_UP;
              POL_LOOK:  side_nxt = dir_r ? SIDE_UP : SIDE_DOWN;
              POL_FLOOK: begin
                lim_nxt    = batch_len;
                active_nxt = batch_len;
              end
              default: side_nxt = SIDE_ANY;
            endcase
          end
        end
      end

      S_SCAN: begin
        // issue one read per cycle
        if (rd_idx_r < lim_r) begin
          rd_idx_nxt  = rd_idx_r + CW'(1);
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = rd_idx_r[AW-1:0];
        end
        // compare the entry read last cycle
        if (cmp_vld_r && seek_take) begin
          best_found_nxt = 1'b1;
          best_idx_nxt   = cmp_idx_r;
          best_dist_nxt  = seek_dist;
          best_track_nxt = rd_track;
          best_tag_nxt   = rd_tag;
        end
        // end of pass
        if ((rd_idx_r == lim_r) && !cmp_vld_r) begin
          if (best_found_r) begin
            res_status_nxt = STAT_GRANTED;
            res_track_nxt  = best_track_r;
            res_tag_nxt    = best_tag_r;
            if (pol_r == POL_FIFO || pol_r == POL_SSTF || pol_r == POL_CLOOK) begin
              if (best_track_r > head_r) begin
                dir_nxt = 1'b1;
              end else if (best_track_r < head_r) begin
                dir_nxt = 1'b0;
              end
            end
            if (CW'(best_idx_r) < active_r) begin
              active_nxt = active_r - CW'(1);
            end
            rd_idx_nxt = CW'(best_idx_r) + CW'(1);
            state_nxt  = S_SHIFT;
          end else begin
            rd_idx_nxt     = '0;
            best_found_nxt = 1'b0;
            pass2_nxt      = 1'b1;
            if (!pass2_r && pol_r == POL_CLOOK) begin
              // wrap around: lowest track overall
              scan_head_nxt = '0;
              side_nxt      = SIDE_ANY;
            end else if (!pass2_r && (pol_r == POL_LOOK || pol_r == POL_FLOOK)) begin
              dir_nxt  = !dir_r;
              side_nxt = dir_r ? SIDE_DOWN : SIDE_UP;
            end else begin
              // safety net, oldest entry
              side_nxt = SIDE_ANY;
              lim_nxt  = CW'(1);
            end
          end
        end
      end

      S_SHIFT: begin
        // read entry i, write it back at i-1
        if (rd_idx_r < count_r) begin
          rd_idx_nxt  = rd_idx_r + CW'(1);
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = rd_idx_r[AW-1:0];
        end
        if (cmp_vld_r) begin
          mem_we    = 1'b1;
          mem_waddr = cmp_idx_r - AW'(1);
          mem_wdata = mem_rdata_r;
        end
        if ((rd_idx_r >= count_r) && !cmp_vld_r) begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_FIN;
        end
      end

      S_FIN: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_track_nxt  = FIELD_BITS'(res_track_r);
          out_tag_nxt    = res_tag_r;
          out_sweep_nxt  = dir_r;
          out_empty_nxt  = (count_r == '0);
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // table write and registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      policy_r    <= POL_FIFO;
      count_r     <= '0;
      active_r    <= '0;
      dir_r       <= 1'b1;
      out_valid_r <= 1'b0;
      cmp_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      policy_r    <= policy_nxt;
      count_r     <= count_nxt;
      active_r    <= active_nxt;
      dir_r       <= dir_nxt;
      out_valid_r <= out_valid_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pol_r        <= pol_nxt;
    side_r       <= side_nxt;
    head_r       <= head_nxt;
    scan_head_r  <= scan_head_nxt;
    lim_r        <= lim_nxt;
    rd_idx_r     <= rd_idx_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    pass2_r      <= pass2_nxt;
    best_found_r <= best_found_nxt;
    best_idx_r   <= best_idx_nxt;
    best_dist_r  <= best_dist_nxt;
    best_track_r <= best_track_nxt;
    best_tag_r   <= best_tag_nxt;
    res_status_r <= res_status_nxt;
    res_track_r  <= res_track_nxt;
    res_tag_r    <= res_tag_nxt;
    out_status_r <= out_status_nxt;
    out_track_r  <= out_track_nxt;
    out_tag_r    <= out_tag_nxt;
    out_sweep_r  <= out_sweep_nxt;
    out_empty_r  <= out_empty_nxt;
  end

  // checks
  `DRS_ASSERT_IMPLY(a_count_range, 1'b1, count_r <= CW'(QUEUE_DEPTH), "entry count past depth")
  `DRS_ASSERT_IMPLY(a_batch_within, 1'b1, active_r <= count_r, "active batch longer than table")
  `DRS_ASSERT_IMPLY(a_scan_bound, state_r == S_SCAN, rd_idx_r <= lim_r, "scan read past limit")
  `DRS_ASSERT_NEXT(a_empty_poll, poll_on_empty, res_status_r == STAT_NONE, "empty poll missed")

endmodule

[sv/drs_seek_unit.sv]
// shared seek compare: side check, seek distance and better-than-best test
module drs_seek_unit #(
  parameter int TRACK_BITS = drs_pkg::TRACK_BITS_DEF
) (
  input  drs_pkg::side_t         side,
  input  logic [TRACK_BITS-1:0]  track,
  input  logic [TRACK_BITS-1:0]  head,
  input  logic                   best_found,
  input  logic [TRACK_BITS-1:0]  best_dist,
  output logic                   take,
  output logic [TRACK_BITS-1:0]  seek_len
);
  import drs_pkg::*;

  logic at_or_above;
  logic at_or_below;
  logic on_side;

  assign at_or_above = (track >= head);
  assign at_or_below = (track <= head);
  assign seek_len    = at_or_above ? (track - head) : (head - track);

  always_comb begin
    unique case (side)
      SIDE_ANY:  on_side = 1'b1;
      SIDE_UP:   on_side = at_or_above;
      SIDE_DOWN: on_side = at_or_below;
      default:   on_side = 1'b0;
    endcase
  end

  // strict less-than keeps the oldest on ties
  assign take = on_side && (!best_found || (seek_len < best_dist));

endmodule
